FILE: hw/rtl/bcsc_pkg.sv
// ----------------------------------------------------------------------------
// Box collision side classifier package
// Shared side codes, field widths, register reset value and per-axis flags.
// ----------------------------------------------------------------------------
package bcsc_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int SIZE_BITS      = 20;
  localparam int VEL_BITS       = 16;
  localparam int MASK_BITS      = 4;
  localparam int TOL_BITS       = 8;
  localparam int SIDE_BITS      = 4;

  localparam logic [SIDE_BITS-1:0] SIDE_NONE   = 4'd0;
  localparam logic [SIDE_BITS-1:0] SIDE_LEFT   = 4'd1;
  localparam logic [SIDE_BITS-1:0] SIDE_RIGHT  = 4'd2;
  localparam logic [SIDE_BITS-1:0] SIDE_TOP    = 4'd4;
  localparam logic [SIDE_BITS-1:0] SIDE_BOTTOM = 4'd8;

  localparam logic [MASK_BITS-1:0] FULL_MASK = 4'd15;
  localparam logic [TOL_BITS-1:0]  TOL_RESET = 8'd28;

  // Width of the internal sums: room for a coordinate or a size, plus the
  // doubled centre terms, with no wrap.
  function automatic int calc_bits(input int coord_bits);
    int base;
    base = (coord_bits > SIZE_BITS + 1) ? coord_bits : SIZE_BITS + 1;
    return base + 4;
  endfunction

  // Per-axis contact result. lo_hit is left or top, hi_hit is right or bottom.
  typedef struct packed {
    logic lo_hit;
    logic hi_hit;
    logic centre_neg;
    logic centre_pos;
  } axis_flags_t;

endpackage

FILE: hw/rtl/bcsc_axis.sv
// ----------------------------------------------------------------------------
// Box collision axis test
// Two register stages for one axis: edge sums first, then the contact tests,
// the overlap and the centre difference.
// ----------------------------------------------------------------------------
module bcsc_axis #(
  parameter int COORD_BITS = bcsc_pkg::COORD_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         en_sum,
  input  logic                                         en_test,
  input  logic signed [COORD_BITS-1:0]                 pos_a,
  input  logic        [bcsc_pkg::SIZE_BITS-1:0]        size_a,
  input  logic signed [COORD_BITS-1:0]                 pos_b,
  input  logic        [bcsc_pkg::SIZE_BITS-1:0]        size_b,
  input  logic signed [bcsc_pkg::VEL_BITS-1:0]         vel,
  input  logic        [bcsc_pkg::TOL_BITS-1:0]         tol,
  output logic signed [bcsc_pkg::calc_bits(COORD_BITS)-1:0] overlap,
  output logic        [bcsc_pkg::calc_bits(COORD_BITS)-1:0] centre_abs,
  output bcsc_pkg::axis_flags_t                        flags
);
  import bcsc_pkg::*;

  localparam int CW = calc_bits(COORD_BITS);

  logic signed [CW-1:0] pa, pb, wa, wb, ve, te;

  // Sum stage registers.
  logic signed [CW-1:0] moved, moved_end, moved_end_tol;
  logic signed [CW-1:0] b_end, b_end_tol, a_tol, a_end, b_start, b_tol;
  logic signed [CW-1:0] centre_a2, centre_b2;

  logic signed [CW-1:0] lo_edge, hi_edge, diff;
  logic                 lo_c, hi_c;

  assign pa = {{(CW-COORD_BITS){pos_a[COORD_BITS-1]}}, pos_a};
  assign pb = {{(CW-COORD_BITS){pos_b[COORD_BITS-1]}}, pos_b};
  assign wa = {{(CW-SIZE_BITS){1'b0}}, size_a};
  assign wb = {{(CW-SIZE_BITS){1'b0}}, size_b};
  assign ve = {{(CW-VEL_BITS){vel[VEL_BITS-1]}}, vel};
  assign te = {{(CW-TOL_BITS){1'b0}}, tol};

  always_ff @(posedge clk) begin
    if (en_sum) begin
      moved         <= pa + ve;
      moved_end     <= pa + ve + wa;
      moved_end_tol <= pa + ve + wa + te;
      b_end         <= pb + wb;
      b_end_tol     <= pb + wb + te;
      a_tol         <= pa + te;
      a_end         <= pa + wa;
      b_start       <= pb;
      b_tol         <= pb + te;
      // Centres are kept doubled so that they stay exact.
      centre_a2     <= {pa[CW-2:0], 1'b0} + {ve[CW-2:0], 1'b0} + wa;
      centre_b2     <= {pb[CW-2:0], 1'b0} + wb;
    end
  end

  always_comb begin
    lo_c    = (moved < b_end_tol) && (a_tol > b_end);
    hi_c    = !lo_c && (moved_end_tol > b_start) && (a_end < b_tol);
    lo_edge = (moved_end < b_end) ? moved_end : b_end;
    hi_edge = (moved > b_start) ? moved : b_start;
    diff    = centre_a2 - centre_b2;
  end

  always_ff @(posedge clk) begin
    if (en_test) begin
      overlap          <= lo_edge - hi_edge;
      centre_abs       <= diff[CW-1] ? -diff : diff;
      flags.lo_hit     <= lo_c;
      flags.hi_hit     <= hi_c;
      flags.centre_neg <= diff[CW-1];
      flags.centre_pos <= !diff[CW-1] && (diff != '0);
    end
  end

endmodule

FILE: hw/rtl/box_collision_side_classifier_top.sv
// ----------------------------------------------------------------------------
// Box collision side classifier
// Moves the first box by the relative velocity, tests each side against the
// edge tolerance and reports one hit side per box pair.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled, through four
// register stages (input, edge sums, axis tests, result); a stalled output fills
// empty stages first.
// Reset clears every valid flag and loads the edge tolerance with 28.
module box_collision_side_classifier_top #(
  parameter int COORD_BITS = bcsc_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bcsc_pkg::TOL_BITS-1:0]         cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          first_pos_x,
  input  logic signed [COORD_BITS-1:0]          first_pos_y,
  input  logic [bcsc_pkg::SIZE_BITS-1:0]        first_size_x,
  input  logic [bcsc_pkg::SIZE_BITS-1:0]        first_size_y,
  input  logic signed [COORD_BITS-1:0]          second_pos_x,
  input  logic signed [COORD_BITS-1:0]          second_pos_y,
  input  logic [bcsc_pkg::SIZE_BITS-1:0]        second_size_x,
  input  logic [bcsc_pkg::SIZE_BITS-1:0]        second_size_y,
  input  logic signed [bcsc_pkg::VEL_BITS-1:0]  rel_vel_x,
  input  logic signed [bcsc_pkg::VEL_BITS-1:0]  rel_vel_y,
  input  logic [bcsc_pkg::MASK_BITS-1:0]        first_mask,
  input  logic [bcsc_pkg::MASK_BITS-1:0]        second_mask,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [bcsc_pkg::SIDE_BITS-1:0]        hit_side
);
  import bcsc_pkg::*;

  localparam int CW = calc_bits(COORD_BITS);

  logic [TOL_BITS-1:0] tol;

  // Input register.
  logic                         v_in;
  logic signed [COORD_BITS-1:0] p1x, p1y, p2x, p2y;
  logic [SIZE_BITS-1:0]         w1x, w1y, w2x, w2y;
  logic signed [VEL_BITS-1:0]   vx, vy;
  logic [MASK_BITS-1:0]         m1, m2;

  logic v_sum, v_test;
  logic full_sum, full_test;

  logic                  rdy_out, rdy_test, rdy_sum, rdy_in;

  logic signed [CW-1:0]  ovl_x, ovl_y;
  logic [CW-1:0]         cabs_x, cabs_y;
  axis_flags_t           fl_x, fl_y;

  logic [SIDE_BITS-1:0]  horiz, vert, res_base, res_pick, hit_side_next;
  logic                  a_pos, b_pos;

  // Each stage moves on when it is empty or the stage after it moves.
  assign rdy_out  = !out_valid || !out_stall;
  assign rdy_test = !v_test || rdy_out;
  assign rdy_sum  = !v_sum || rdy_test;
  assign rdy_in   = !v_in || rdy_sum;
  assign in_stall = !rdy_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol       <= TOL_RESET;
      v_in      <= 1'b0;
      v_sum     <= 1'b0;
      v_test    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol <= cfg_wdata;
      end
      if (rdy_in) begin
        v_in <= in_valid;
      end
      if (rdy_sum) begin
        v_sum <= v_in;
      end
      if (rdy_test) begin
        v_test <= v_sum;
      end
      if (rdy_out) begin
        out_valid <= v_test;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_in) begin
      p1x <= first_pos_x;
      p1y <= first_pos_y;
      w1x <= first_size_x;
      w1y <= first_size_y;
      p2x <= second_pos_x;
      p2y <= second_pos_y;
      w2x <= second_size_x;
      w2y <= second_size_y;
      vx  <= rel_vel_x;
      vy  <= rel_vel_y;
      m1  <= first_mask;
      m2  <= second_mask;
    end
    if (rdy_sum) begin
      full_sum <= (m1 == FULL_MASK) && (m2 == FULL_MASK);
    end
    if (rdy_test) begin
      full_test <= full_sum;
    end
    if (rdy_out) begin
      hit_side <= hit_side_next;
    end
  end

  bcsc_axis #(
    .COORD_BITS(COORD_BITS)
  ) u_axis_x (
    .clk        (clk),
    .en_sum     (rdy_sum),
    .en_test    (rdy_test),
    .pos_a      (p1x),
    .size_a     (w1x),
    .pos_b      (p2x),
    .size_b     (w2x),
    .vel        (vx),
    .tol        (tol),
    .overlap    (ovl_x),
    .centre_abs (cabs_x),
    .flags      (fl_x)
  );

  bcsc_axis #(
    .COORD_BITS(COORD_BITS)
  ) u_axis_y (
    .clk        (clk),
    .en_sum     (rdy_sum),
    .en_test    (rdy_test),
    .pos_a      (p1y),
    .size_a     (w1y),
    .pos_b      (p2y),
    .size_b     (w2y),
    .vel        (vy),
    .tol        (tol),
    .overlap    (ovl_y),
    .centre_abs (cabs_y),
    .flags      (fl_y)
  );

  always_comb begin
    a_pos = (ovl_x > 0);
    b_pos = (ovl_y > 0);

    horiz = fl_x.lo_hit ? SIDE_LEFT : (fl_x.hi_hit ? SIDE_RIGHT : SIDE_NONE);
    vert  = fl_y.lo_hit ? SIDE_TOP : (fl_y.hi_hit ? SIDE_BOTTOM : SIDE_NONE);

    res_base = (b_pos || (vert != SIDE_NONE)) ? horiz : SIDE_NONE;
    if ((a_pos || (horiz != SIDE_NONE)) && (vert != SIDE_NONE) &&
        ((res_base == SIDE_NONE) || (ovl_x > ovl_y))) begin
      res_pick = vert;
    end else begin
      res_pick = res_base;
    end

    // Deep overlap of two fully collidable boxes: the centres decide.
    if (a_pos && b_pos && (res_pick == SIDE_NONE) && full_test) begin
      if (cabs_x > cabs_y) begin
        hit_side_next = horiz | (fl_x.centre_neg ? SIDE_RIGHT :
                                 (fl_x.centre_pos ? SIDE_LEFT : SIDE_NONE));
      end else begin
        hit_side_next = vert | (fl_y.centre_neg ? SIDE_BOTTOM :
                                (fl_y.centre_pos ? SIDE_TOP : SIDE_NONE));
      end
    end else begin
      hit_side_next = res_pick;
    end
  end

endmodule
